### hdl/permutation_rank_unrank_defines.svh
// Assertion macros shared by the permutation rank/unrank design.
// Each expects clk and rst_n in the enclosing module.
`ifndef PERMUTATION_RANK_UNRANK_DEFINES_SVH
`define PERMUTATION_RANK_UNRANK_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/prr_pkg.sv
package prr_pkg;

    localparam int PERM_SIZE_DEF = 8;
    localparam int MAX_SIZE      = 8;
    localparam int ELEM_W        = 3;
    localparam int RANK_W        = 16;
    localparam int FACT_W        = RANK_W + 1;
    localparam int DIGIT_W       = 3;
    localparam int TDATA_W       = 40;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic                       action;
        logic                       invalid;
        logic [RANK_W-1:0]          acc;
        logic [RANK_W-1:0]          rem;
        elem_t [MAX_SIZE-1:0]       cnt;
        logic [MAX_SIZE-1:0]        used;
        elem_t [MAX_SIZE-1:0]       elem;
    } item_t;

    function automatic logic [FACT_W-1:0] fact_of(input int k);
        logic [FACT_W-1:0] f;
        case (k)
            0:       f = FACT_W'(1);
            1:       f = FACT_W'(1);
            2:       f = FACT_W'(2);
            3:       f = FACT_W'(6);
            4:       f = FACT_W'(24);
            5:       f = FACT_W'(120);
            6:       f = FACT_W'(720);
            7:       f = FACT_W'(5040);
            8:       f = FACT_W'(40320);
            default: f = FACT_W'(1);
        endcase
        return f;
    endfunction

endpackage

### hdl/prr_front.sv
`include "permutation_rank_unrank_defines.svh"

module prr_front
    import prr_pkg::*;
#(
    parameter int PERM_SIZE = PERM_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [RANK_W-1:0]    rank_in,
    input  elem_t [MAX_SIZE-1:0] elem_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_data
);

    localparam logic [FACT_W-1:0] LIMIT = fact_of(PERM_SIZE);

    logic  valid_reg;
    item_t data_reg;
    item_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // count later, smaller elements for every position
    always_comb
    begin
        data_next         = '0;
        data_next.action  = action;
        data_next.invalid = action && (FACT_W'(rank_in) >= LIMIT);
        data_next.rem     = rank_in;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            for (int j = 0; j < MAX_SIZE; j++)
            begin
                if (i < PERM_SIZE && j > i && j < PERM_SIZE && elem_in[j] < elem_in[i])
                begin
                    data_next.cnt[i] = data_next.cnt[i] + ELEM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    `PRR_ASSERT_NEXT(a_front_range,
        in_valid && in_ready && action && (FACT_W'(rank_in) >= LIMIT),
        valid_reg && data_reg.invalid,
        "out-of-range rank not flagged")

endmodule

### hdl/prr_stage.sv
`include "permutation_rank_unrank_defines.svh"

module prr_stage
    import prr_pkg::*;
#(
    parameter int PERM_SIZE = PERM_SIZE_DEF,
    parameter int POS       = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_data
);

    localparam logic [FACT_W-1:0] F = fact_of(PERM_SIZE - 1 - POS);

    logic               valid_reg;
    item_t              data_reg;
    item_t              data_next;
    logic [DIGIT_W-1:0] digit;
    logic [FACT_W-1:0]  sub;
    logic [FACT_W-1:0]  prod;
    logic [RANK_W-1:0]  addend;
    logic [DIGIT_W:0]   seen;
    logic               found;
    elem_t              pick;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        digit     = '0;
        sub       = '0;
        addend    = '0;
        prod      = '0;
        seen      = '0;
        found     = 1'b0;
        pick      = '0;

        // factorial-base digit by compare against multiples of F, and rank addend cnt[POS] * F
        for (int k = 1; k < MAX_SIZE; k++)
        begin
            prod = FACT_W'(k) * F;
            if (k < PERM_SIZE - POS && FACT_W'(in_data.rem) >= prod)
            begin
                digit = DIGIT_W'(k);
                sub   = prod;
            end
            if (in_data.cnt[POS] == ELEM_W'(k))
            begin
                addend = RANK_W'(prod);
            end
        end
        data_next.rem = in_data.rem - RANK_W'(sub);
        data_next.acc = in_data.acc + addend;

        // take the digit-th unused value
        for (int v = 0; v < MAX_SIZE; v++)
        begin
            if (v < PERM_SIZE && !in_data.used[v] && !found)
            begin
                if (seen == {1'b0, digit})
                begin
                    found = 1'b1;
                    pick  = ELEM_W'(v);
                end
                else
                begin
                    seen = seen + (DIGIT_W+1)'(1);
                end
            end
        end
        if (found)
        begin
            data_next.used[pick] = 1'b1;
        end
        data_next.elem[POS] = pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    `PRR_ASSERT_NEXT(a_stage_hold,
        valid_reg && !out_ready,
        valid_reg && $stable(data_reg),
        "stalled stage lost or changed its request")
    `PRR_ASSERT_NOW(a_stage_used,
        valid_reg && data_reg.action && !data_reg.invalid,
        $countones(data_reg.used) == POS + 1,
        "unrank picked no free value")

endmodule

### hdl/permutation_rank_unrank.sv
// Structure: one register per stage; a front stage counts smaller later elements,
// then one stage per position adds a weighted count and picks an unused value.
// Throughput: one request per cycle while the output is not stalled.
// Stalls back up through the per-stage valid bits without loss or repeat.
// Reset: rst_n is asynchronous, active low, and clears only the stage valid bits.
`include "permutation_rank_unrank_defines.svh"

module permutation_rank_unrank
    import prr_pkg::*;
#(
    parameter int PERM_SIZE = PERM_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // rank_in, elem0_in .. elem7_in
    input  logic               s_axis_tuser,   // action
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // rank_out, elem0_out .. elem7_out
    output logic               m_axis_tuser    // rank_invalid
);

    localparam logic [FACT_W-1:0] LIMIT = fact_of(PERM_SIZE);

    logic  [PERM_SIZE:0]   pipe_valid;
    logic  [PERM_SIZE:0]   pipe_ready;
    item_t                 pipe_data [PERM_SIZE+1];
    elem_t [MAX_SIZE-1:0]  elem_in;
    elem_t [MAX_SIZE-1:0]  elem_o;
    logic  [RANK_W-1:0]    rank_o;
    logic  [MAX_SIZE-1:0]  seen;
    item_t                 last;

    assign elem_in = s_axis_tdata[TDATA_W-1:RANK_W];

    prr_front #(
        .PERM_SIZE (PERM_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .rank_in   (s_axis_tdata[RANK_W-1:0]),
        .elem_in   (elem_in),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    for (genvar g = 0; g < PERM_SIZE; g++)
    begin : g_stage
        prr_stage #(
            .PERM_SIZE (PERM_SIZE),
            .POS       (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_data   (pipe_data[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_data  (pipe_data[g+1])
        );
    end

    assign pipe_ready[PERM_SIZE] = m_axis_tready;
    assign last                  = pipe_data[PERM_SIZE];

    assign rank_o        = last.action ? '0 : last.acc;
    assign elem_o        = (last.action && !last.invalid) ? last.elem : '0;
    assign m_axis_tvalid = pipe_valid[PERM_SIZE];
    assign m_axis_tdata  = {elem_o, rank_o};
    assign m_axis_tuser  = last.action && last.invalid;

    always_comb
    begin
        seen = '0;
        for (int p = 0; p < MAX_SIZE; p++)
        begin
            if (p < PERM_SIZE)
            begin
                seen[elem_o[p]] = 1'b1;
            end
        end
    end

    `PRR_ASSERT_NOW(a_rank_bound,
        m_axis_tvalid && !last.action,
        FACT_W'(rank_o) < LIMIT,
        "rank result beyond factorial")
    `PRR_ASSERT_NOW(a_unrank_perm,
        m_axis_tvalid && last.action && !last.invalid,
        $countones(seen) == PERM_SIZE,
        "unrank result is not a permutation")

endmodule
